[rtl/ihex_pkg.sv]
// Shared types, constants and helpers for the Intel HEX record parser.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

   // Result kinds
   localparam logic [2:0] KIND_DATA   = 3'd0;
   localparam logic [2:0] KIND_FILL   = 3'd1;
   localparam logic [2:0] KIND_START  = 3'd2;
   localparam logic [2:0] KIND_WARN   = 3'd3;
   localparam logic [2:0] KIND_FINISH = 3'd4;

   // Warning codes
   localparam logic [2:0] WARN_BAD_PAIR = 3'd0;
   localparam logic [2:0] WARN_TRAILING = 3'd1;

   // Finish codes
   localparam logic [2:0] FIN_NORMAL    = 3'd0;
   localparam logic [2:0] FIN_NON_DATA  = 3'd1;
   localparam logic [2:0] FIN_COLON     = 3'd2;
   localparam logic [2:0] FIN_BAD_ADDR  = 3'd3;
   localparam logic [2:0] FIN_BACKWARDS = 3'd4;
   localparam logic [2:0] FIN_SHORT     = 3'd5;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   localparam logic [7:0]  FILL_BYTE    = 8'hFF;
   localparam logic [9:0]  HEADER_CHARS = 10'd11;
   localparam logic [9:0]  NO_DATA_LIM  = 10'd9;
   localparam logic [9:0]  POS_MAX      = 10'd1023;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } in_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [16:0] byte_address;
      logic [15:0] fill_count;
      logic [2:0]  code;
      logic [15:0] records_read;
   } out_type;

   // Hex digit value; bit 4 set marks a non-hex character
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      d = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) d = {1'b0, c[3:0]};
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         d = {1'b0, c[3:0] + 4'd9};
      return d;
   endfunction

endpackage

`default_nettype wire

[rtl/intel_hex_record_to_binary_core.sv]
// Intel HEX record parser: one text character per request, zero or one result.
`timescale 1ns / 1ps
`default_nettype none

// Takes Intel HEX text one character per request and returns data bytes with
// their addresses, 0xFF gap fill runs, the first record's start address,
// warnings, and a final finish result carrying a status code. Each character
// is decoded in a single pass of logic from the request port into the result
// register, so one request is taken every clock cycle; the only stall comes
// from the result register when a result is waiting and rsp_ready is low.
// The result is registered and appears in the cycle after its request. After a
// finish result the block produces nothing until reset.
module intel_hex_record_to_binary_core
   import ihex_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire in_type req_payload,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output out_type     rsp_payload
);

   logic        stopped_ff, stopped_in;
   logic [9:0]  pos_ff, pos_in;
   logic        skip_ff, skip_in;
   logic [15:0] rec_cnt_ff, rec_cnt_in;
   logic [16:0] exp_addr_ff, exp_addr_in;
   logic        start_known_ff, start_known_in;
   logic [15:0] addr_acc_ff, addr_acc_in;
   logic        addr_bad_ff, addr_bad_in;
   logic [9:0]  data_lim_ff, data_lim_in;
   logic        type_ok_ff, type_ok_in;
   logic [4:0]  nibble_ff, nibble_in;

   logic        rsp_valid_ff, rsp_valid_in;
   out_type     rsp_payload_ff, rsp_payload_in;

   logic        req_fire;
   logic        emit;
   out_type     rsp_next;
   logic [7:0]  c;
   logic [4:0]  h;
   logic        term;
   logic        line_short;
   logic [10:0] p_plus2;
   logic [15:0] acc_base;
   logic        bad_base;
   logic [16:0] addr_v;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign c          = req_payload.char_in;
   assign h          = hex_digit(c);
   assign term       = (c == CH_CR) || (c == CH_LF) || (c == CH_SP);
   assign line_short = (pos_ff < NO_DATA_LIM) || (pos_ff < data_lim_ff);
   assign p_plus2    = {1'b0, pos_ff} + 11'd2;
   assign addr_v     = {1'b0, addr_acc_ff};

   always_comb begin
      stopped_in     = stopped_ff;
      pos_in         = pos_ff;
      skip_in        = skip_ff;
      rec_cnt_in     = rec_cnt_ff;
      exp_addr_in    = exp_addr_ff;
      start_known_in = start_known_ff;
      addr_acc_in    = addr_acc_ff;
      addr_bad_in    = addr_bad_ff;
      data_lim_in    = data_lim_ff;
      type_ok_in     = type_ok_ff;
      nibble_in      = nibble_ff;
      emit           = 1'b0;
      rsp_next       = '0;
      acc_base       = (pos_ff == 10'd3) ? 16'd0 : addr_acc_ff;
      bad_base       = (pos_ff == 10'd3) ? 1'b0 : addr_bad_ff;

      if (req_fire && !stopped_ff) begin
         if (req_payload.end_of_input) begin
            emit          = 1'b1;
            stopped_in    = 1'b1;
            rsp_next.kind = KIND_FINISH;
            rsp_next.code = (pos_ff != 10'd0 && !skip_ff && line_short) ?
                            FIN_SHORT : FIN_NORMAL;
         end else if (skip_ff) begin
            if (c == CH_LF) skip_in = 1'b0;
         end else if (pos_ff == 10'd0) begin
            if (term) begin
               emit          = 1'b1;
               stopped_in    = 1'b1;
               rsp_next.kind = KIND_FINISH;
               rsp_next.code = FIN_NORMAL;
            end else begin
               if (rec_cnt_ff != COUNT_MAX) rec_cnt_in = rec_cnt_ff + 16'd1;
               if (c != CH_COLON) begin
                  emit          = 1'b1;
                  stopped_in    = 1'b1;
                  rsp_next.kind = KIND_FINISH;
                  rsp_next.code = FIN_COLON;
               end else begin
                  data_lim_in = 10'd0;
                  pos_in      = 10'd1;
               end
            end
         end else if (term) begin
            if (line_short) begin
               emit          = 1'b1;
               stopped_in    = 1'b1;
               rsp_next.kind = KIND_FINISH;
               rsp_next.code = FIN_SHORT;
            end else begin
               pos_in  = 10'd0;
               skip_in = (c != CH_LF);
            end
         end else begin
            if (pos_ff != POS_MAX) pos_in = pos_ff + 10'd1;
            priority if (pos_ff == 10'd1) begin
               nibble_in = h;
            end else if (pos_ff == 10'd2) begin
               if (nibble_ff[4] || h[4])
                  data_lim_in = NO_DATA_LIM;
               else
                  data_lim_in = {1'b0, nibble_ff[3:0], h[3:0], 1'b0} + HEADER_CHARS;
            end else if (pos_ff >= 10'd3 && pos_ff <= 10'd6) begin
               if (h[4]) begin
                  addr_bad_in = 1'b1;
                  addr_acc_in = acc_base;
               end else begin
                  addr_bad_in = bad_base;
                  addr_acc_in = {acc_base[11:0], h[3:0]};
               end
            end else if (pos_ff == 10'd7) begin
               type_ok_in = (c == CH_ZERO);
            end else if (pos_ff == 10'd8) begin
               priority if (!type_ok_ff || c != CH_ZERO) begin
                  emit          = 1'b1;
                  stopped_in    = 1'b1;
                  rsp_next.kind = KIND_FINISH;
                  rsp_next.code = FIN_NON_DATA;
               end else if (addr_bad_ff) begin
                  emit          = 1'b1;
                  stopped_in    = 1'b1;
                  rsp_next.kind = KIND_FINISH;
                  rsp_next.code = FIN_BAD_ADDR;
               end else if (!start_known_ff) begin
                  emit                  = 1'b1;
                  start_known_in        = 1'b1;
                  exp_addr_in           = addr_v;
                  rsp_next.kind         = KIND_START;
                  rsp_next.byte_address = addr_v;
               end else if (addr_v > exp_addr_ff) begin
                  // expected is below 64K here, so the gap fits 16 bits
                  emit                  = 1'b1;
                  exp_addr_in           = addr_v;
                  rsp_next.kind         = KIND_FILL;
                  rsp_next.data_byte    = FILL_BYTE;
                  rsp_next.byte_address = exp_addr_ff;
                  rsp_next.fill_count   = 16'(addr_v - exp_addr_ff);
               end else if (addr_v < exp_addr_ff) begin
                  emit          = 1'b1;
                  stopped_in    = 1'b1;
                  rsp_next.kind = KIND_FINISH;
                  rsp_next.code = FIN_BACKWARDS;
               end else begin
                  emit = 1'b0;
               end
            end else begin
               // data pairs start at position 9: odd positions hold high nibbles
               if (p_plus2 < {1'b0, data_lim_ff}) begin
                  if (pos_ff[0]) begin
                     nibble_in = h;
                  end else if (nibble_ff[4] || h[4]) begin
                     emit          = 1'b1;
                     rsp_next.kind = KIND_WARN;
                     rsp_next.code = WARN_BAD_PAIR;
                  end else begin
                     emit                  = 1'b1;
                     exp_addr_in           = exp_addr_ff + 17'd1;
                     rsp_next.kind         = KIND_DATA;
                     rsp_next.data_byte    = {nibble_ff[3:0], h[3:0]};
                     rsp_next.byte_address = exp_addr_ff;
                  end
               end else if (pos_ff == data_lim_ff) begin
                  emit          = 1'b1;
                  rsp_next.kind = KIND_WARN;
                  rsp_next.code = WARN_TRAILING;
               end
            end
         end
      end
      rsp_next.records_read = rec_cnt_in;
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff     <= 1'b0;
         pos_ff         <= '0;
         skip_ff        <= 1'b0;
         rec_cnt_ff     <= '0;
         exp_addr_ff    <= '0;
         start_known_ff <= 1'b0;
         addr_acc_ff    <= '0;
         addr_bad_ff    <= 1'b0;
         data_lim_ff    <= '0;
         type_ok_ff     <= 1'b0;
         nibble_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stopped_ff     <= stopped_in;
         pos_ff         <= pos_in;
         skip_ff        <= skip_in;
         rec_cnt_ff     <= rec_cnt_in;
         exp_addr_ff    <= exp_addr_in;
         start_known_ff <= start_known_in;
         addr_acc_ff    <= addr_acc_in;
         addr_bad_ff    <= addr_bad_in;
         data_lim_ff    <= data_lim_in;
         type_ok_ff     <= type_ok_in;
         nibble_ff      <= nibble_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // once stopped, only the finish result may still be waiting
   a_stop_holds_finish: assert property (@(posedge clock) disable iff (reset)
      stopped_ff && rsp_valid_ff |-> rsp_payload_ff.kind == KIND_FINISH)
      else $error("result other than finish after stop");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled with empty result register");

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.kind == KIND_FILL |-> rsp_payload_ff.fill_count != 16'd0)
      else $error("zero-length fill run");

   a_skip_at_line_start: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> pos_ff == 10'd0)
      else $error("skipping inside a record");

endmodule

`default_nettype wire
